// File: rtl/dcd_pkg.sv
// ============================================================================
// dcd_pkg: shared constants for the day count to calendar date converter
// Holds the field widths, the epoch offset and the tables that drive the
// subtract steps of the pipeline and the month lookup.
// ============================================================================
`default_nettype none

package dcd_pkg;

   localparam int DAY_COUNT_W = 22;
   localparam int YEAR_W      = 14;
   localparam int MONTH_W     = 4;
   localparam int DAY_W       = 5;
   localparam int WEEKDAY_W   = 3;

   // Working width of the shifted day count.
   localparam int REM_W = DAY_COUNT_W + 1;
   // Day of a March-based year, 0 to 365.
   localparam int DOY_W = 9;
   // Digit sum of the day count in base 8, before folding.
   localparam int WK_W  = 6;

   // The count is moved so that day zero is 1600-03-01. That date opens a
   // 400-year cycle and puts the leap day at the end of each year.
   localparam logic [REM_W-1:0] DAY_OFFSET = REM_W'(146037);
   localparam logic [YEAR_W-1:0] EPOCH_YEAR = YEAR_W'(1600);

   // Restoring subtract steps: 400-year cycles (five quotient bits), centuries
   // (two bits), four-year groups (five bits) and single years (two bits).
   // Each taken step adds its weight in years.
   localparam int NUM_STEPS = 14;

   localparam logic [REM_W-1:0] STEP_DIVISOR [NUM_STEPS] = '{
      REM_W'(2337552), REM_W'(1168776), REM_W'(584388), REM_W'(292194),
      REM_W'(146097),  REM_W'(73048),   REM_W'(36524),  REM_W'(23376),
      REM_W'(11688),   REM_W'(5844),    REM_W'(2922),   REM_W'(1461),
      REM_W'(730),     REM_W'(365)
   };

   localparam logic [YEAR_W-1:0] STEP_WEIGHT [NUM_STEPS] = '{
      YEAR_W'(6400), YEAR_W'(3200), YEAR_W'(1600), YEAR_W'(800),
      YEAR_W'(400),  YEAR_W'(200),  YEAR_W'(100),  YEAR_W'(64),
      YEAR_W'(32),   YEAR_W'(16),   YEAR_W'(8),    YEAR_W'(4),
      YEAR_W'(2),    YEAR_W'(1)
   };

   // Step after which the remainder lies within one 400-year cycle.
   localparam int CYCLE_STEPS = 5;
   localparam logic [REM_W-1:0] DAYS_PER_CYCLE = REM_W'(146097);

   // First day of each month in a year that starts on March 1.
   localparam int NUM_MONTHS = 12;
   localparam logic [DOY_W-1:0] MONTH_START [NUM_MONTHS] = '{
      DOY_W'(0),   DOY_W'(31),  DOY_W'(61),  DOY_W'(92),
      DOY_W'(122), DOY_W'(153), DOY_W'(184), DOY_W'(214),
      DOY_W'(245), DOY_W'(275), DOY_W'(306), DOY_W'(337)
   };

   // March-based month index of January; January and February belong to
   // the next calendar year.
   localparam logic [MONTH_W-1:0] MP_JANUARY = MONTH_W'(10);
   localparam logic [MONTH_W-1:0] MONTH_MARCH_OFFSET = MONTH_W'(3);
   localparam logic [MONTH_W-1:0] MONTH_JANUARY_OFFSET = MONTH_W'(9);
   localparam logic [MONTH_W-1:0] MONTH_FEBRUARY = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_APRIL = MONTH_W'(4);
   localparam logic [MONTH_W-1:0] MONTH_JUNE = MONTH_W'(6);
   localparam logic [MONTH_W-1:0] MONTH_SEPTEMBER = MONTH_W'(9);
   localparam logic [MONTH_W-1:0] MONTH_NOVEMBER = MONTH_W'(11);

   localparam logic [WEEKDAY_W-1:0] DAYS_PER_WEEK = WEEKDAY_W'(7);

endpackage : dcd_pkg

`default_nettype wire

// File: rtl/day_count_to_calendar_date_core.sv
// ============================================================================
// day_count_to_calendar_date_core: days since 2000-01-01 to Gregorian date
// Converts a day count into year, month, day of month and weekday through a
// pipeline of restoring subtract steps followed by a month lookup.
// ============================================================================
//
//   Channel   Ports                       Direction   Contents
//   req       req_valid, req_stall        in          day_count
//   rsp       rsp_valid, rsp_stall        out         year, month,
//                                                     day_of_month, weekday
//
// A new transaction can enter in every clock cycle while req_stall is low;
// each one passes through the input stage, the fourteen subtract stages,
// the month compare stage and the output stage.
// Reset clears the valid bit of every stage; data registers are not reset.
// When the result waits on rsp_stall, the whole pipeline holds and req_stall
// is raised in the same cycle, so nothing is lost or repeated.
//
`default_nettype none

module day_count_to_calendar_date_core
   import dcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [DAY_COUNT_W-1:0] req_day_count,

   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [YEAR_W-1:0]      rsp_year,
   output      logic [MONTH_W-1:0]     rsp_month,
   output      logic [DAY_W-1:0]       rsp_day_of_month,
   output      logic [WEEKDAY_W-1:0]   rsp_weekday
);

   // Base-8 digits of the day count, with the top digit padded with zeros.
   localparam int WK_DIGITS = (DAY_COUNT_W + 2) / 3;
   localparam int PAD_W     = 3 * WK_DIGITS;

   // The pipeline moves as one whenever the output register is empty or is
   // being taken in this cycle.
   logic advance;

   // Digit sum of the incoming count.
   logic [WK_W-1:0] in_digit_sum;

   // Subtract pipeline: entry 0 is the input stage, entry k+1 follows step k.
   logic               vld_ff  [NUM_STEPS+1];
   logic [REM_W-1:0]   rem_ff  [NUM_STEPS+1];
   logic [YEAR_W-1:0]  year_ff [NUM_STEPS+1];
   logic [WK_W-1:0]    wk_ff   [NUM_STEPS+1];
   logic [REM_W-1:0]   rem_in  [NUM_STEPS+1];
   logic [YEAR_W-1:0]  year_in [NUM_STEPS+1];
   logic [WK_W-1:0]    wk_in   [NUM_STEPS+1];

   // Month compare stage.
   logic                 m1_vld_ff;
   logic [MONTH_W-1:0]   m1_mp_ff;
   logic [DOY_W-1:0]     m1_doy_ff;
   logic [YEAR_W-1:0]    m1_year_ff;
   logic [WEEKDAY_W-1:0] m1_wk_ff;
   logic [MONTH_W-1:0]   m1_mp_in;
   logic [DOY_W-1:0]     m1_doy_in;

   // Output stage.
   logic                 out_vld_ff;
   logic [YEAR_W-1:0]    out_year_ff;
   logic [MONTH_W-1:0]   out_month_ff;
   logic [DAY_W-1:0]     out_day_ff;
   logic [WEEKDAY_W-1:0] out_wk_ff;
   logic [YEAR_W-1:0]    out_year_in;
   logic [MONTH_W-1:0]   out_month_in;
   logic [DAY_W-1:0]     out_day_in;

   assign advance   = !out_vld_ff || !rsp_stall;
   assign req_stall = !advance;

   // Input stage: shift the epoch and form the base-8 digit sum of the count.
   // Since 8 is 1 modulo 7, the digit sum has the same remainder as the count.
   always_comb begin
      logic [PAD_W-1:0] count_pad;
      count_pad    = PAD_W'(req_day_count);
      in_digit_sum = '0;
      for (int i = 0; i < WK_DIGITS; i++) begin
         in_digit_sum = in_digit_sum + WK_W'(count_pad[3*i +: 3]);
      end
   end

   assign rem_in[0]  = REM_W'(req_day_count) + DAY_OFFSET;
   assign year_in[0] = EPOCH_YEAR;
   assign wk_in[0]   = in_digit_sum;

   // One restoring step per stage. When the remainder reaches the step's
   // divisor, the divisor is taken off and its span in years is added.
   // The first two stages also fold the weekday sum down to 0 to 6.
   for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
      localparam logic [REM_W-1:0]  DIVISOR = STEP_DIVISOR[k];
      localparam logic [YEAR_W-1:0] WEIGHT  = STEP_WEIGHT[k];
      logic take;

      assign take          = rem_ff[k] >= DIVISOR;
      assign rem_in[k+1]   = take ? rem_ff[k] - DIVISOR : rem_ff[k];
      assign year_in[k+1]  = take ? year_ff[k] + WEIGHT : year_ff[k];

      if (k == 0) begin : g_fold
         assign wk_in[k+1] = WK_W'(wk_ff[k][WK_W-1:3]) + WK_W'(wk_ff[k][2:0]);
      end else if (k == 1) begin : g_reduce
         assign wk_in[k+1] = (wk_ff[k] >= WK_W'(DAYS_PER_WEEK))
                             ? wk_ff[k] - WK_W'(DAYS_PER_WEEK) : wk_ff[k];
      end else begin : g_pass
         assign wk_in[k+1] = wk_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= NUM_STEPS; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int j = 1; j <= NUM_STEPS; j++) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int j = 0; j <= NUM_STEPS; j++) begin
            rem_ff[j]  <= rem_in[j];
            year_ff[j] <= year_in[j];
            wk_ff[j]   <= wk_in[j];
         end
      end
   end

   // After the last step the remainder is the day of a March-based year.
   // Each month start is compared on its own; the highest one passed wins.
   always_comb begin
      m1_doy_in = rem_ff[NUM_STEPS][DOY_W-1:0];
      m1_mp_in  = '0;
      for (int i = 1; i < NUM_MONTHS; i++) begin
         if (m1_doy_in >= MONTH_START[i]) begin
            m1_mp_in = MONTH_W'(i);
         end
      end
   end

   // January and February close the March-based year, so they count toward
   // the following calendar year.
   always_comb begin
      logic [DOY_W-1:0] day_offset;
      day_offset   = m1_doy_ff - MONTH_START[m1_mp_ff];
      out_day_in   = day_offset[DAY_W-1:0] + DAY_W'(1);
      if (m1_mp_ff >= MP_JANUARY) begin
         out_month_in = m1_mp_ff - MONTH_JANUARY_OFFSET;
         out_year_in  = m1_year_ff + YEAR_W'(1);
      end else begin
         out_month_in = m1_mp_ff + MONTH_MARCH_OFFSET;
         out_year_in  = m1_year_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         m1_vld_ff  <= vld_ff[NUM_STEPS];
         out_vld_ff <= m1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_mp_ff     <= m1_mp_in;
         m1_doy_ff    <= m1_doy_in;
         m1_year_ff   <= year_ff[NUM_STEPS];
         m1_wk_ff     <= wk_ff[NUM_STEPS][WEEKDAY_W-1:0];
         out_year_ff  <= out_year_in;
         out_month_ff <= out_month_in;
         out_day_ff   <= out_day_in;
         out_wk_ff    <= m1_wk_ff;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_year         = out_year_ff;
   assign rsp_month        = out_month_ff;
   assign rsp_day_of_month = out_day_ff;
   assign rsp_weekday      = out_wk_ff;

`ifndef NO_ASSERTIONS
   // An accepted transaction always lands in the input stage.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   // Once the 400-year steps are done, the remainder lies within one 400-year cycle.
   a_cycle_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[CYCLE_STEPS] |-> (rem_ff[CYCLE_STEPS] < DAYS_PER_CYCLE))
      else $error("remainder left the 400-year cycle");

   // After the last step, the remainder is a day within one year.
   a_year_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NUM_STEPS] |-> (rem_ff[NUM_STEPS] <= REM_W'(365)))
      else $error("remainder left the year");

   // The day of the month fits the month that goes with it.
   a_month_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_day_of_month != '0) &&
         (!(rsp_month == MONTH_FEBRUARY) || (rsp_day_of_month <= DAY_W'(29))) &&
         (!(rsp_month == MONTH_APRIL || rsp_month == MONTH_JUNE ||
            rsp_month == MONTH_SEPTEMBER || rsp_month == MONTH_NOVEMBER) ||
          (rsp_day_of_month <= DAY_W'(30))))
      else $error("day of month exceeds the month length");
`endif

endmodule : day_count_to_calendar_date_core

`default_nettype wire

// File: tb/day_count_to_calendar_date_core_tb.sv
// ============================================================================
// day_count_to_calendar_date_core_tb: self-checking bench for the date core
// Sends day counts through the req channel and compares every rsp
// transaction with a date computed here by walking cycles, years and months.
// Traffic runs under several idle and stall mixes, a long output hold-off
// and a full drain before more input arrives.
// ============================================================================

module day_count_to_calendar_date_core_tb;
   import dcd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Calendar arithmetic used by the date predictor below.
   localparam int unsigned FIRST_YEAR        = 2000;
   localparam int unsigned DAYS_PER_400Y     = 146097;
   localparam int unsigned DAYS_PER_CENTURY  = 36524;
   localparam int unsigned WEEK_LENGTH       = 7;
   localparam int unsigned MONTH_JANUARY     = 1;
   localparam int unsigned MONTH_DECEMBER    = 12;
   localparam int unsigned MAX_DAY_COUNT     = (1 << DAY_COUNT_W) - 1;

   // Run control. The pipeline holds seventeen transactions in flight, and
   // PIPE_SETTLE gives anything still moving through the time to come out.
   localparam int unsigned PIPE_SETTLE       = 40;
   localparam int unsigned RSP_HOLD_CYCLES   = 300;
   localparam int unsigned WATCHDOG_LIMIT    = 5000;
   localparam int unsigned ITEMS_PER_PHASE   = 130;

   typedef struct packed {
      logic [YEAR_W-1:0]    year;
      logic [MONTH_W-1:0]   month;
      logic [DAY_W-1:0]     day_of_month;
      logic [WEEKDAY_W-1:0] weekday;
   } calendar_date_type;

   logic                   clock         = 1'b0;
   logic                   reset         = 1'b1;
   logic                   req_valid     = 1'b0;
   logic                   req_stall;
   logic [DAY_COUNT_W-1:0] req_day_count = '0;
   logic                   rsp_valid;
   logic                   rsp_stall     = 1'b0;
   logic [YEAR_W-1:0]      rsp_year;
   logic [MONTH_W-1:0]     rsp_month;
   logic [DAY_W-1:0]       rsp_day_of_month;
   logic [WEEKDAY_W-1:0]   rsp_weekday;

   // Idle mix, in percent of cycles, for the sender and the receiver.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // A one-cycle request from the test sequence starts a long hold-off that
   // the receiver process counts down on its own.
   logic        rsp_hold_start = 1'b0;
   int unsigned rsp_hold_left = 0;

   calendar_date_type pending_dates [$];
   int unsigned       mismatch_count = 0;
   int unsigned       quiet_cycles = 0;

   always #2ns clock = ~clock;

   day_count_to_calendar_date_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_day_count    (req_day_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_weekday      (rsp_weekday)
   );

   // -------------------------------------------------------------------------
   // Date predictor
   // -------------------------------------------------------------------------

   function automatic bit is_leap_year(input int unsigned year);
      if ((year % 4) != 0) return 1'b0;
      if ((year % 100) != 0) return 1'b1;
      return (year % 400) == 0;
   endfunction

   function automatic int unsigned days_in_month(input int unsigned month, input bit leap);
      case (month)
         MONTH_FEBRUARY: return leap ? 29 : 28;
         MONTH_APRIL, MONTH_JUNE, MONTH_SEPTEMBER, MONTH_NOVEMBER: return 30;
         default: return 31;
      endcase
   endfunction

   // Whole 400-year cycles are taken off first since 2000 opens one; the
   // remainder is then walked a year at a time and the day within the year a
   // month at a time. 2000-01-01 was a Saturday, which is weekday zero.
   function automatic calendar_date_type convert_day_count(
      input logic [DAY_COUNT_W-1:0] count
   );
      int unsigned       days;
      int unsigned       year;
      int unsigned       rest;
      int unsigned       year_len;
      int unsigned       month;
      bit                leap;
      calendar_date_type date;
      days = count;
      year = FIRST_YEAR + 400 * (days / DAYS_PER_400Y);
      rest = days % DAYS_PER_400Y;
      year_len = is_leap_year(year) ? 366 : 365;
      while (rest >= year_len) begin
         rest -= year_len;
         year++;
         year_len = is_leap_year(year) ? 366 : 365;
      end
      leap = is_leap_year(year);
      month = MONTH_JANUARY;
      while (month < MONTH_DECEMBER && rest >= days_in_month(month, leap)) begin
         rest -= days_in_month(month, leap);
         month++;
      end
      date.year         = YEAR_W'(year);
      date.month        = MONTH_W'(month);
      date.day_of_month = DAY_W'(rest + 1);
      date.weekday      = WEEKDAY_W'(days % WEEK_LENGTH);
      return date;
   endfunction

   // -------------------------------------------------------------------------
   // Channel processes
   // -------------------------------------------------------------------------

   // Every accepted req transaction queues its predicted date. Sampling at the
   // edge reads the values that the block itself sampled.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         pending_dates.push_back(convert_day_count(req_day_count));
   end

   // Receiver: random stall, or a counted hold-off when one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold_left <= 0;
      end else if (rsp_hold_left != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left <= rsp_hold_left - 1;
      end else if (rsp_hold_start) begin
         rsp_stall <= 1'b1;
         rsp_hold_left <= RSP_HOLD_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // Each accepted rsp transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      calendar_date_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_dates.size() == 0) begin
            $error("rsp transaction with none pending: year %0d month %0d day %0d",
                   rsp_year, rsp_month, rsp_day_of_month);
            mismatch_count++;
         end else begin
            want = pending_dates.pop_front();
            if (rsp_year !== want.year) begin
               $error("year: expected %0d, got %0d", want.year, rsp_year);
               mismatch_count++;
            end
            if (rsp_month !== want.month) begin
               $error("month: expected %0d, got %0d", want.month, rsp_month);
               mismatch_count++;
            end
            if (rsp_day_of_month !== want.day_of_month) begin
               $error("day_of_month: expected %0d, got %0d",
                      want.day_of_month, rsp_day_of_month);
               mismatch_count++;
            end
            if (rsp_weekday !== want.weekday) begin
               $error("weekday: expected %0d, got %0d", want.weekday, rsp_weekday);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: a run that stops moving on both channels for too long is hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL day_count_to_calendar_date_core");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Offers one day count and returns at the edge where it is accepted. Valid
   // stays high afterwards so that back-to-back transactions need no gap.
   task automatic send_day_count(input logic [DAY_COUNT_W-1:0] count);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_day_count <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted date has been checked.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   // Mixes the full range with counts near century and cycle boundaries,
   // where the leap rules bite, and with small counts in the first years.
   function automatic logic [DAY_COUNT_W-1:0] random_day_count();
      int unsigned pick;
      int unsigned count;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         count = $urandom_range(0, MAX_DAY_COUNT);
      end else if (pick < 7) begin
         count = $urandom_range(0, 28) * DAYS_PER_400Y
               + $urandom_range(0, 3) * DAYS_PER_CENTURY
               + $urandom_range(0, 1500);
         if (count > MAX_DAY_COUNT) count = count % (MAX_DAY_COUNT + 1);
      end else begin
         count = $urandom_range(0, 3000);
      end
      return DAY_COUNT_W'(count);
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Month ends around leap days in an ordinary leap year, a leap century
   // and a plain century, the cycle boundary, the largest counts and bit
   // patterns that toggle every input bit.
   task automatic test_calendar_corners();
      logic [DAY_COUNT_W-1:0] corner_counts [$] = '{
         DAY_COUNT_W'(0),       DAY_COUNT_W'(1),       DAY_COUNT_W'(30),
         DAY_COUNT_W'(31),      DAY_COUNT_W'(58),      DAY_COUNT_W'(59),
         DAY_COUNT_W'(60),      DAY_COUNT_W'(365),     DAY_COUNT_W'(366),
         DAY_COUNT_W'(1460),    DAY_COUNT_W'(1520),    DAY_COUNT_W'(36524),
         DAY_COUNT_W'(36525),   DAY_COUNT_W'(36583),   DAY_COUNT_W'(36584),
         DAY_COUNT_W'(146096),  DAY_COUNT_W'(146097),  DAY_COUNT_W'(146156),
         DAY_COUNT_W'(4194302), DAY_COUNT_W'(4194303), 22'h2AAAAA,
         22'h155555,            22'h200000,            22'h1FFFFF
      };
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      foreach (corner_counts[i]) send_day_count(corner_counts[i]);
      wait_for_drain();
   endtask

   // Random counts under one mix of sender gaps and receiver stalls.
   task automatic test_random_traffic(input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (ITEMS_PER_PHASE) send_day_count(random_day_count());
      wait_for_drain();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering, so the pipeline fills and pushes back on req_stall.
   task automatic test_output_backpressure();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_start <= 1'b1;
      @(posedge clock);
      rsp_hold_start <= 1'b0;
      repeat (60) send_day_count(random_day_count());
      wait_for_drain();
   endtask

   // The sender pauses until every result is back, then resumes into an
   // empty pipeline.
   task automatic test_restart_after_drain();
      req_idle_pct = 20;
      rsp_stall_pct = 20;
      repeat (10) send_day_count(random_day_count());
      wait_for_drain();
      repeat (20) send_day_count(random_day_count());
      wait_for_drain();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_calendar_corners();
      test_random_traffic(10, 71);
      test_random_traffic(71, 10);
      test_random_traffic(0, 0);
      test_output_backpressure();
      test_restart_after_drain();

      // Let anything stray surface before the verdict.
      wait_for_drain();
      repeat (PIPE_SETTLE) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS day_count_to_calendar_date_core");
      else
         $display("FAIL day_count_to_calendar_date_core");
      $finish;
   end

endmodule
